// File: src/mpwc_pkg.sv
// Shared types and constants for the multichannel pulse-width capture block.
// Used by every module in src; depends on nothing.
package mpwc_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int PERIOD_DEF   = 20000;
  localparam int QUEUE_DEPTH  = 2;

  localparam int CH_FIELD_W  = 3;
  localparam int COUNT_W     = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 24;

  // Input word kind, carried on s_tuser
  localparam logic CMD_WRAP    = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Finished measurement handed from the front to the back
  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [COUNT_W-1:0]    stop_count;
    logic [COUNT_W-1:0]    start_count;
    logic                  wrapped;
  } mpwc_job_t;

  // Push side of the job queue
  typedef struct packed {
    logic      valid;
    mpwc_job_t job;
  } mpwc_push_t;

  // Pop side of the job queue
  typedef struct packed {
    logic      valid;
    mpwc_job_t job;
  } mpwc_head_t;

endpackage

// File: src/mpwc_front.sv
// Front part: accepts input words, keeps per-channel measuring state and
// classifies each word. Depends on mpwc_pkg.
module mpwc_front #(
  parameter int CHANNELS = mpwc_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             command,
  input  logic [mpwc_pkg::CH_FIELD_W-1:0]  channel,
  input  logic [mpwc_pkg::COUNT_W-1:0]     counter_value,
  output mpwc_pkg::mpwc_push_t             push
);
  import mpwc_pkg::*;

  logic [CHANNELS-1:0] measuring;
  logic [CHANNELS-1:0] wrapped;
  logic [COUNT_W-1:0]  start_count [CHANNELS];

  logic [CHANNELS-1:0] hit;
  logic                sel_meas;
  logic                sel_wrap;
  logic [COUNT_W-1:0]  sel_start;
  logic                is_capture;

  assign is_capture = (command == CMD_CAPTURE);

  // Decode the channel; out-of-range channels hit nothing
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      hit[k] = ({2'b00, channel} == 5'(k));
    end
  end

  always_comb begin
    sel_meas  = 1'b0;
    sel_wrap  = 1'b0;
    sel_start = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (hit[k]) begin
        sel_meas  = measuring[k];
        sel_wrap  = wrapped[k];
        sel_start = start_count[k];
      end
    end
  end

  // A capture on a channel that is already measuring completes a pulse
  always_comb begin
    push.valid           = accept && is_capture && (|hit) && sel_meas;
    push.job.channel     = channel;
    push.job.stop_count  = counter_value;
    push.job.start_count = sel_start;
    push.job.wrapped     = sel_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measuring <= '0;
      wrapped   <= '0;
    end else if (accept) begin
      if (!is_capture) begin
        // Mark every running measurement; a second wrap changes nothing
        wrapped <= wrapped | measuring;
      end else begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (hit[k]) begin
            measuring[k] <= !measuring[k];
            wrapped[k]   <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_capture) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (hit[k] && !measuring[k]) begin
          start_count[k] <= counter_value;
        end
      end
    end
  end

endmodule

// File: src/mpwc_queue.sv
// Short job queue between the front and the back.
// Depends on mpwc_pkg.
module mpwc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mpwc_pkg::mpwc_push_t push,
  input  logic                 pop,
  output mpwc_pkg::mpwc_head_t head,
  output logic                 full
);
  import mpwc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mpwc_job_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.job;
    end
  end

endmodule

// File: src/mpwc_back.sv
// Back part: computes the pulse width of a queued job and holds it in the
// output register until taken. Depends on mpwc_pkg.
module mpwc_back #(
  parameter int PERIOD = mpwc_pkg::PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mpwc_pkg::mpwc_head_t             head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpwc_pkg::CH_FIELD_W-1:0]  result_channel,
  output logic [mpwc_pkg::COUNT_W-1:0]     pulse_width
);
  import mpwc_pkg::*;

  // A full period of 65536 vanishes modulo 2^16
  localparam logic [COUNT_W-1:0] PERIOD_MOD = COUNT_W'(PERIOD % 65536);

  logic [COUNT_W-1:0] width_next;

  assign pop = head.valid && (!out_valid || out_ready);

  assign width_next = head.job.stop_count
                    + (head.job.wrapped ? PERIOD_MOD : '0)
                    - head.job.start_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_channel <= head.job.channel;
      pulse_width    <= width_next;
    end
  end

endmodule

// File: src/multichannel_pulse_width_capture.sv
// Top level of the multichannel pulse-width capture block: front, job queue
// and back. Depends on mpwc_pkg, mpwc_front, mpwc_queue and mpwc_back.
//
//   Group   Dir  Signals                       Payload
//   s_*     in   s_tvalid s_tready s_tdata     tdata: channel, counter_value
//                s_tuser                       tuser: command
//   m_*     out  m_tvalid m_tready m_tdata     tdata: result_channel, pulse_width
//
// One word is taken per cycle while s_tready is high; a completed pulse passes
// through the queue stage and the output register before it reaches m_tdata.
// s_tready drops only while the two-entry job queue is full, which needs a
// stall on m_tready. rst is synchronous and active high: it returns every
// channel to idle and empties the queue and output register. No clearing
// pass is needed after reset.
module multichannel_pulse_width_capture #(
  parameter int CHANNELS = mpwc_pkg::CHANNELS_DEF,
  parameter int PERIOD   = mpwc_pkg::PERIOD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mpwc_pkg::S_TDATA_W-1:0]   s_tdata,   // [2:0] channel, [18:3] counter_value
  input  logic                             s_tuser,   // [0] command (0 wrap, 1 capture)
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mpwc_pkg::M_TDATA_W-1:0]   m_tdata    // [2:0] result_channel, [18:3] pulse_width
);
  import mpwc_pkg::*;

  mpwc_push_t              push;
  mpwc_head_t              head;
  logic                    q_full;
  logic                    pop;
  logic                    accept;
  logic [CH_FIELD_W-1:0]   result_channel;
  logic [COUNT_W-1:0]      pulse_width;

  // Hold input while the queue cannot take a finished pulse
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  mpwc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (s_tuser),
    .channel       (s_tdata[CH_FIELD_W-1:0]),
    .counter_value (s_tdata[CH_FIELD_W+COUNT_W-1:CH_FIELD_W]),
    .push          (push)
  );

  mpwc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  mpwc_back #(
    .PERIOD (PERIOD)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .result_channel (result_channel),
    .pulse_width    (pulse_width)
  );

  // Pack the result word; pad upper bits with zeros
  assign m_tdata = {(M_TDATA_W - CH_FIELD_W - COUNT_W)'(0), pulse_width, result_channel};

endmodule
